// File: sv/cts_pkg.sv
package cts_pkg;

  localparam int unsigned InW    = 31;
  localparam int unsigned SumW   = 31;
  localparam int unsigned TolW   = 31;
  localparam int unsigned CountW = 4;
  localparam int unsigned DivW   = 9;

  localparam logic [TolW-1:0] TolReset = TolW'(268);
  localparam logic [SumW-1:0] SumMax   = {SumW{1'b1}};

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    logic              done;
  } cts_acc_t;

endpackage

// File: sv/cts_term_step.sv
module cts_term_step #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned TERM_IDX  = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [cts_pkg::TolW-1:0] tolerance_i,
  input  logic                   valid_i,
  input  logic [FRAC_BITS+1:0]   term_i,
  input  logic [FRAC_BITS+2:0]   x2_i,
  input  cts_pkg::cts_acc_t      acc_i,
  output logic                   valid_o,
  output logic [FRAC_BITS+1:0]   term_o,
  output logic [FRAC_BITS+2:0]   x2_o,
  output cts_pkg::cts_acc_t      acc_o
);
  import cts_pkg::*;

  localparam int unsigned TermW  = FRAC_BITS + 2;
  localparam int unsigned X2W    = FRAC_BITS + 3;
  localparam int unsigned PW     = FRAC_BITS + 4;
  localparam int unsigned RecipW = FRAC_BITS + 4;
  localparam int unsigned ProdW  = TermW + X2W;
  localparam int unsigned EstW   = PW + RecipW;
  localparam int unsigned QdW    = PW + DivW;
  localparam int unsigned Div    = (2 * TERM_IDX + 1) * (2 * TERM_IDX + 2);
  localparam logic [DivW-1:0]   DivC      = DivW'(Div);
  localparam logic [63:0]       RecipFull = (64'd1 << RecipW) / 64'(Div);
  localparam logic [RecipW-1:0] Recip     = RecipFull[RecipW-1:0];

  // stage a: stop check, accumulate, term times x2
  logic             below;
  logic [SumW:0]    sum_add;
  logic [ProdW-1:0] prod;
  cts_acc_t         acc_a_d, acc_a_q, acc_b_q, acc_c_q;
  logic [PW-1:0]    p_a_q, p_b_q;
  logic [X2W-1:0]   x2_a_q, x2_b_q, x2_c_q;
  logic             va_q, vb_q, vc_q;

  assign below   = {{(TolW-TermW){1'b0}}, term_i} < tolerance_i;
  assign sum_add = {1'b0, acc_i.sum} + (SumW+1)'(term_i);
  assign prod    = ProdW'(term_i) * ProdW'(x2_i);

  always_comb begin
    acc_a_d = acc_i;
    if (!acc_i.done) begin
      if (below) begin
        acc_a_d.done = 1'b1;
      end else begin
        acc_a_d.sum   = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
        acc_a_d.count = CountW'(TERM_IDX + 1);
      end
    end
  end

  // stage b: reciprocal multiply
  logic [EstW-1:0] est;
  logic [PW-1:0]   q_b_q;

  assign est = EstW'(p_a_q) * EstW'(Recip);

  // stage c: quotient correction
  logic [QdW-1:0] qd;
  logic [PW-1:0]  rem;
  logic [PW-1:0]  q_fix;
  logic [TermW-1:0] term_c_q;

  assign qd    = QdW'(q_b_q) * QdW'(DivC);
  assign rem   = p_b_q - qd[PW-1:0];
  assign q_fix = (rem >= PW'(DivC)) ? q_b_q + PW'(1) : q_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q    <= prod[FRAC_BITS+PW-1:FRAC_BITS];
      x2_a_q   <= x2_i;
      acc_a_q  <= acc_a_d;
      q_b_q    <= est[EstW-1:RecipW];
      p_b_q    <= p_a_q;
      x2_b_q   <= x2_a_q;
      acc_b_q  <= acc_a_q;
      term_c_q <= q_fix[TermW-1:0];
      x2_c_q   <= x2_b_q;
      acc_c_q  <= acc_b_q;
    end
  end

  assign valid_o = vc_q;
  assign term_o  = term_c_q;
  assign x2_o    = x2_c_q;
  assign acc_o   = acc_c_q;

endmodule

// File: sv/cosh_taylor_series_core.sv
// channel  | handshake                  | payload
// input    | in_valid_i / in_stall_o    | x_value_i
// output   | out_valid_o / out_stall_i  | series_sum_o, terms_added_o, hit_limit_o
// config   | cfg_we_i                   | cfg_wdata_i (tolerance)
//
// one beat per cycle in while the output is not stalled; each series term is
// three stages: product, reciprocal multiply, quotient correction
// async active-low reset empties the pipe and loads tolerance with 268
// a stalled output beat freezes the whole pipe; in_stall_o follows at once
module cosh_taylor_series_core #(
  parameter int unsigned MAX_TERMS = 11,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cts_pkg::TolW-1:0]        cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [cts_pkg::InW-1:0]  x_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cts_pkg::SumW-1:0]        series_sum_o,
  output logic [cts_pkg::CountW-1:0]      terms_added_o,
  output logic                            hit_limit_o
);
  import cts_pkg::*;

  localparam int unsigned MagW  = FRAC_BITS + 2;
  localparam int unsigned TermW = FRAC_BITS + 2;
  localparam int unsigned X2W   = FRAC_BITS + 3;
  localparam int unsigned SqW   = 2 * MagW;
  localparam logic [InW-1:0]   MagLimit = InW'(2) << FRAC_BITS;
  localparam logic [TermW-1:0] TermOne  = TermW'(1) << FRAC_BITS;

  logic en;
  logic [TolW-1:0] tol_q;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // magnitude, saturated to 2.0
  logic [InW-1:0]  raw_u, abs_v;
  logic [MagW-1:0] mag_d, mag_q;
  logic            v0_q, v1_q;
  logic [SqW-1:0]  sq;
  logic [X2W-1:0]  x2_q;

  assign raw_u = x_value_i;
  assign abs_v = raw_u[InW-1] ? (~raw_u + InW'(1)) : raw_u;
  assign mag_d = (abs_v > MagLimit) ? MagLimit[MagW-1:0] : abs_v[MagW-1:0];
  assign sq    = SqW'(mag_q) * SqW'(mag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i && !in_stall_o;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= mag_d;
      x2_q  <= sq[FRAC_BITS+X2W-1:FRAC_BITS];
    end
  end

  // term chain
  logic             vld_s  [MAX_TERMS+1];
  logic [TermW-1:0] term_s [MAX_TERMS+1];
  logic [X2W-1:0]   x2_s   [MAX_TERMS+1];
  cts_acc_t         acc_s  [MAX_TERMS+1];

  assign vld_s[0]  = v1_q;
  assign term_s[0] = TermOne;
  assign x2_s[0]   = x2_q;
  assign acc_s[0]  = '{sum: '0, count: '0, done: 1'b0};

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_term
    cts_term_step #(
      .FRAC_BITS(FRAC_BITS),
      .TERM_IDX (g)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .tolerance_i(tol_q),
      .valid_i    (vld_s[g]),
      .term_i     (term_s[g]),
      .x2_i       (x2_s[g]),
      .acc_i      (acc_s[g]),
      .valid_o    (vld_s[g+1]),
      .term_o     (term_s[g+1]),
      .x2_o       (x2_s[g+1]),
      .acc_o      (acc_s[g+1])
    );
  end

  // output register, final term decides the limit flag
  logic              out_valid_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic              hit_q;
  logic              last_below;
  cts_acc_t          acc_last;

  assign acc_last   = acc_s[MAX_TERMS];
  assign last_below = {{(TolW-TermW){1'b0}}, term_s[MAX_TERMS]} < tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_s[MAX_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= acc_last.sum;
      count_q <= acc_last.count;
      hit_q   <= !acc_last.done && !last_below;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign series_sum_o  = sum_q;
  assign terms_added_o = count_q;
  assign hit_limit_o   = hit_q;

endmodule

// File: sv/cts_checker.sv
module cts_checker #(
  parameter int unsigned MAX_TERMS = 11
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [cts_pkg::SumW-1:0]     series_sum_o,
  input logic [cts_pkg::CountW-1:0]   terms_added_o,
  input logic                         hit_limit_o
);
  import cts_pkg::*;

  // stalled output beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(series_sum_o))
    else $error("stalled output beat dropped or changed");

  // stalled output freezes the input side
  a_in_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input not stalled while output beat waits");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_limit_o |-> terms_added_o == CountW'(MAX_TERMS))
    else $error("limit flag without full term count");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && terms_added_o == '0 |-> series_sum_o == '0 && !hit_limit_o)
    else $error("nonzero sum with no terms added");

endmodule

bind cosh_taylor_series_core cts_checker #(
  .MAX_TERMS(MAX_TERMS)
) u_cts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .series_sum_o (series_sum_o),
  .terms_added_o(terms_added_o),
  .hit_limit_o  (hit_limit_o)
);
